/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define PNC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define PNC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/pnc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pnc_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [7:0][31:0]  t_state;   // [0] = a ... [7] = h
    typedef logic [15:0][31:0] t_win;     // [0] = W for the current round

    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned CNT_W    = 7;
    localparam logic [6:0]  DIFF_RST = 7'd5;
    localparam logic [3:0]  ASCII_HI = 4'h3;   // upper nibble of '0'
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam t_state INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word k_at(input logic [5:0] idx);
        t_word r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
            6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
            6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
            6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
            6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
            6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
            6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
            6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
            6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
            6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
            6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/pnc_dec.sv */
`timescale 1ns / 1ps
`default_nettype none
module pnc_dec import pnc_pkg::*; #(
    parameter int unsigned NonceBits = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [NonceBits-1:0] i_nonce,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_win                      o_win,
    output logic [NonceBits-1:0]      o_nonce
);

    // shift-and-add-3 conversion, one binary bit per stage
    logic                 r_v     [NonceBits];
    logic [BCD_W-1:0]     r_bcd   [NonceBits];
    logic [NonceBits-1:0] r_bin   [NonceBits];
    logic [NonceBits-1:0] r_nonce [NonceBits];
    logic                 en      [NonceBits];
    logic                 pad_en;

    logic                 r_pv;
    t_win                 r_win;
    logic [NonceBits-1:0] r_pnonce;

    assign o_ready = en[0];

    for (genvar k = 0; k < NonceBits; k++) begin : g_dd
        logic                 in_v;
        logic [BCD_W-1:0]     in_bcd;
        logic [NonceBits-1:0] in_bin;
        logic [NonceBits-1:0] in_nonce;
        logic [BCD_W-1:0]     adj;
        logic                 nx_en;

        if (k == 0) begin : g_src0
            assign in_v     = i_valid;
            assign in_bcd   = '0;
            assign in_bin   = i_nonce;
            assign in_nonce = i_nonce;
        end else begin : g_srcn
            assign in_v     = r_v[k-1];
            assign in_bcd   = r_bcd[k-1];
            assign in_bin   = r_bin[k-1];
            assign in_nonce = r_nonce[k-1];
        end

        if (k == NonceBits - 1) begin : g_last
            assign nx_en = pad_en;
        end else begin : g_mid
            assign nx_en = en[k+1];
        end

        assign en[k] = !r_v[k] || nx_en;

        always_comb begin
            adj = in_bcd;
            for (int j = 0; j < DIGITS; j++) begin
                if (in_bcd[4*j +: 4] >= 4'd5) begin
                    adj[4*j +: 4] = in_bcd[4*j +: 4] + 4'd3;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_bcd[k]   <= {adj[BCD_W-2:0], in_bin[NonceBits-1]};
                r_bin[k]   <= {in_bin[NonceBits-2:0], 1'b0};
                r_nonce[k] <= in_nonce;
            end
        end
    end

    // message block from the decimal digits
    logic [BCD_W-1:0] dig;
    logic [3:0]       len;
    logic [3:0]       di;
    logic [7:0]       msg [11];
    t_win             n_win;

    assign dig    = r_bcd[NonceBits-1];
    assign pad_en = !r_pv || i_ready;

    always_comb begin
        len = 4'd1;
        di  = '0;
        for (int j = 1; j < DIGITS; j++) begin
            if (dig[4*j +: 4] != 4'd0) begin
                len = 4'(j + 1);
            end
        end
        for (int p = 0; p < 11; p++) begin
            di = len - 4'(p) - 4'd1;
            if (4'(p) < len) begin
                msg[p] = {ASCII_HI, dig[4*di +: 4]};
            end else if (4'(p) == len) begin
                msg[p] = PAD_BYTE;
            end else begin
                msg[p] = 8'h00;
            end
        end
        n_win     = '0;
        n_win[0]  = {msg[0], msg[1], msg[2], msg[3]};
        n_win[1]  = {msg[4], msg[5], msg[6], msg[7]};
        n_win[2]  = {msg[8], msg[9], msg[10], 8'h00};
        n_win[15] = {25'd0, len, 3'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (pad_en) begin
            r_pv <= r_v[NonceBits-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pad_en) begin
            r_win    <= n_win;
            r_pnonce <= r_nonce[NonceBits-1];
        end
    end

    assign o_valid = r_pv;
    assign o_win   = r_win;
    assign o_nonce = r_pnonce;

endmodule
`default_nettype wire

/* rtl/core/pnc_round.sv */
`timescale 1ns / 1ps
`default_nettype none
module pnc_round import pnc_pkg::*; #(
    parameter int unsigned NonceBits = 32,
    parameter int unsigned RoundIdx  = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_state               i_state,
    input  wire t_win                 i_win,
    input  wire logic [NonceBits-1:0] i_nonce,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_state                    o_state,
    output t_win                      o_win,
    output logic [NonceBits-1:0]      o_nonce
);

    localparam t_word K = k_at(6'(RoundIdx));

    logic                 r_valid;
    t_state               r_state;
    t_win                 r_win;
    logic [NonceBits-1:0] r_nonce;
    logic                 en;
    t_word                t1;
    t_word                t2;
    t_word                w_new;
    t_state               n_state;
    t_win                 n_win;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        t1 = i_state[7] + bsig1(i_state[4])
           + ((i_state[4] & i_state[5]) ^ (~i_state[4] & i_state[6]))
           + K + i_win[0];
        t2 = bsig0(i_state[0])
           + ((i_state[0] & i_state[1]) ^ (i_state[0] & i_state[2])
              ^ (i_state[1] & i_state[2]));
        n_state    = {i_state[6:4], i_state[3] + t1, i_state[2:0], t1 + t2};
        w_new      = ssig1(i_win[14]) + i_win[9] + ssig0(i_win[1]) + i_win[0];
        n_win      = {w_new, i_win[15:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_state <= n_state;
            r_win   <= n_win;
            r_nonce <= i_nonce;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_win   = r_win;
    assign o_nonce = r_nonce;

endmodule
`default_nettype wire

/* rtl/core/pnc_fin.sv */
`timescale 1ns / 1ps
`default_nettype none
module pnc_fin import pnc_pkg::*; #(
    parameter int unsigned NonceBits = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_state               i_state,
    input  wire logic [NonceBits-1:0] i_nonce,
    input  wire logic [CNT_W-1:0]     i_difficulty,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [NonceBits-1:0]      o_nonce,
    output logic [CNT_W-1:0]          o_count,
    output logic                      o_hit
);

    logic                 r_av;
    t_state               r_dig;
    logic [NonceBits-1:0] r_anonce;
    logic                 a_en;

    logic                 r_ov;
    logic [NonceBits-1:0] r_ononce;
    logic [CNT_W-1:0]     r_count;
    logic                 r_hit;
    logic                 o_en;

    logic [3:0]           wz [8];
    logic [CNT_W-1:0]     n_count;
    logic                 run;

    assign o_en    = !r_ov || i_ready;
    assign a_en    = !r_av || o_en;
    assign o_ready = a_en;

    // digest add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (a_en) begin
            r_av <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            for (int j = 0; j < 8; j++) begin
                r_dig[j] <= INIT_H[j] + i_state[j];
            end
            r_anonce <= i_nonce;
        end
    end

    // leading zero nibbles: per word, then across words
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            wz[j] = 4'd8;
            for (int q = 7; q >= 0; q--) begin
                if (r_dig[j][28-4*q +: 4] != 4'd0) begin
                    wz[j] = 4'(q);
                end
            end
        end
        n_count = '0;
        run     = 1'b1;
        for (int j = 0; j < 8; j++) begin
            if (run) begin
                n_count = n_count + CNT_W'(wz[j]);
                run     = (wz[j] == 4'd8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_en) begin
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_ononce <= r_anonce;
            r_count  <= n_count;
            r_hit    <= (n_count == i_difficulty);
        end
    end

    assign o_valid = r_ov;
    assign o_nonce = r_ononce;
    assign o_count = r_count;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

/* rtl/core/pow_nonce_checker_core.sv */
// Channel | Dir | Handshake              | Payload
// s       | in  | i_s_tvalid/o_s_tready  | i_s_tdata[31:0] nonce
// m       | out | o_m_tvalid/i_m_tready  | o_m_tdata: [31:0] nonce_echo, [38:32] zero_count,
//         |     |                        |            [39] hit
// cfg     | in  | i_cfg_valid/o_cfg_ready| i_cfg_data[6:0] difficulty
//
// One nonce per cycle sustained unless i_m_tready stalls the output; every stage is a
// register with its own valid. Stages: one per binary bit of the decimal conversion,
// one for padding, one per SHA-256 round (64), two to finish.
// A stall holds only the full stages behind it; bubbles still close up.
// Reset is synchronous, clears all valid bits, difficulty returns to 5.
`timescale 1ns / 1ps
`default_nettype none
module pow_nonce_checker_core import pnc_pkg::*; #(
    parameter int unsigned NONCE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,    // nonce
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,    // nonce_echo, zero_count, hit
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data    // difficulty
);

    logic [CNT_W-1:0] r_difficulty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_difficulty <= DIFF_RST;
        end else if (i_cfg_valid) begin
            r_difficulty <= i_cfg_data;
        end
    end

    logic                  p_valid [65];
    logic                  p_ready [65];
    t_state                p_state [65];
    t_win                  p_win   [65];
    logic [NONCE_BITS-1:0] p_nonce [65];

    pnc_dec #(.NonceBits(NONCE_BITS)) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_nonce (i_s_tdata[NONCE_BITS-1:0]),
        .o_valid (p_valid[0]),
        .i_ready (p_ready[0]),
        .o_win   (p_win[0]),
        .o_nonce (p_nonce[0])
    );

    assign p_state[0] = INIT_H;

    for (genvar r = 0; r < 64; r++) begin : g_rnd
        pnc_round #(.NonceBits(NONCE_BITS), .RoundIdx(r)) u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (p_valid[r]),
            .o_ready (p_ready[r]),
            .i_state (p_state[r]),
            .i_win   (p_win[r]),
            .i_nonce (p_nonce[r]),
            .o_valid (p_valid[r+1]),
            .i_ready (p_ready[r+1]),
            .o_state (p_state[r+1]),
            .o_win   (p_win[r+1]),
            .o_nonce (p_nonce[r+1])
        );
    end

    logic [NONCE_BITS-1:0] f_nonce;
    logic [CNT_W-1:0]      f_count;
    logic                  f_hit;

    pnc_fin #(.NonceBits(NONCE_BITS)) u_fin (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (p_valid[64]),
        .o_ready      (p_ready[64]),
        .i_state      (p_state[64]),
        .i_nonce      (p_nonce[64]),
        .i_difficulty (r_difficulty),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_nonce      (f_nonce),
        .o_count      (f_count),
        .o_hit        (f_hit)
    );

    assign o_m_tdata = {f_hit, f_count, 32'(f_nonce)};

endmodule
`default_nettype wire

/* rtl/core/pnc_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pnc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic [6:0]  i_cfg_data
);

    logic [6:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= 7'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_diff <= i_cfg_data;
        end
    end

    `PNC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "result beat valid after reset")
    `PNC_ASSERT(a_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled beat changed")
    `PNC_ASSERT(a_cnt_rng, o_m_tvalid |-> o_m_tdata[38:32] <= 7'd64, "zero count above 64")
    `PNC_ASSERT(a_hit, o_m_tvalid |-> o_m_tdata[39] == (o_m_tdata[38:32] == r_diff), "hit disagrees with difficulty")

endmodule

bind pow_nonce_checker_core pnc_chk u_pnc_chk (.*);
`default_nettype wire
